// ----- hw/rtl/mms_pkg.sv -----
// ----------------------------------------------------------------------------
// mms_pkg
// Shared types and constants of the min/max stack: request and response
// payloads, stack entries, action and status codes, and the command and
// status groups that pass between controller and datapath.
// ----------------------------------------------------------------------------
package mms_pkg;

	localparam int unsigned StackDepth = 256;
	localparam int unsigned DataW      = 32;
	localparam int unsigned DepthW     = 9;

	localparam logic [1:0] ACT_PUSH = 2'd0;
	localparam logic [1:0] ACT_POP  = 2'd1;
	localparam logic [1:0] ACT_PEEK = 2'd2;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_POP_EMPTY = 2'd1,
		ST_PUSH_FULL = 2'd2
	} status_t;

	typedef struct packed {
		logic        [1:0]       action;
		logic signed [DataW-1:0] value;
	} req_t;

	typedef struct packed {
		logic signed [DataW-1:0]  top_value;
		logic signed [DataW-1:0]  running_max;
		logic signed [DataW-1:0]  running_min;
		logic        [DataW-1:0]  spread;
		logic        [DepthW-1:0] depth;
		logic                     is_empty;
		status_t                  status;
	} rsp_t;

	typedef struct packed {
		logic signed [DataW-1:0] val;
		logic signed [DataW-1:0] hi;
		logic signed [DataW-1:0] lo;
	} entry_t;

	typedef struct packed {
		logic accept;
		logic load_top;
		logic emit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic need_read;
	} dp_stat_t;

endpackage

// ----- hw/rtl/mms_stream_if.sv -----
// ----------------------------------------------------------------------------
// mms_stream_if
// Valid/ready channel carrying one request or response payload.
// ----------------------------------------------------------------------------
interface mms_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/min_max_stack_core.sv -----
// ----------------------------------------------------------------------------
// min_max_stack_core
// Bounded stack of signed 32-bit values that reports the running maximum,
// minimum and their spread after every push, pop or peek.
//
//   channel | modport | payload
//   --------+---------+-------------------------------------------------
//   cmd     | sink    | action, value
//   rsp     | source  | top_value, running_max, running_min, spread,
//           |         | depth, is_empty, status
//
// A request passes from acceptance through the emit state to its registered
// response; a pop that exposes an entry held in memory first passes through
// the load state, which takes in the registered read of the entry memory. A
// new request is taken only in idle, once the previous response has left or
// leaves in the same cycle. Reset clears only the entry count, status and
// control state; the entry memory needs no clearing pass since only written
// entries are ever read. A stalled response holds the controller in idle.
// ----------------------------------------------------------------------------
module min_max_stack_core #(
	parameter int unsigned STACK_DEPTH = mms_pkg::StackDepth
) (
	input  logic         clk,
	input  logic         arst_n,
	mms_stream_if.sink   cmd,
	mms_stream_if.source rsp
);

	mms_pkg::ctrl_cmd_t ctrl_cmd;
	mms_pkg::dp_stat_t  dp_stat;
	mms_pkg::rsp_t      rsp_data;

	mms_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (cmd.valid),
		.req_ready (cmd.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.stat      (dp_stat),
		.cmd       (ctrl_cmd)
	);

	mms_datapath #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (cmd.data),
		.cmd    (ctrl_cmd),
		.stat   (dp_stat),
		.rsp    (rsp_data)
	);

	assign rsp.data = rsp_data;

endmodule

// ----- hw/rtl/mms_datapath.sv -----
// ----------------------------------------------------------------------------
// mms_datapath
// Top-of-stack register, entry memory for the entries below the top, entry
// counter and response register.
// ----------------------------------------------------------------------------
module mms_datapath #(
	parameter int unsigned STACK_DEPTH = mms_pkg::StackDepth
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mms_pkg::req_t       req,
	input  mms_pkg::ctrl_cmd_t  cmd,
	output mms_pkg::dp_stat_t   stat,
	output mms_pkg::rsp_t       rsp
);

	localparam int unsigned CntW  = $clog2(STACK_DEPTH + 1);
	localparam int unsigned AddrW = $clog2(STACK_DEPTH);

	logic [CntW-1:0]        count_q;
	mms_pkg::status_t       status_q;
	mms_pkg::entry_t        top_q;
	mms_pkg::entry_t        rdata_q;
	mms_pkg::rsp_t          rsp_q;
	mms_pkg::entry_t        mem [STACK_DEPTH];

	logic                   is_push;
	logic                   is_pop;
	logic                   empty;
	logic                   full;
	logic                   mem_we;
	logic [AddrW-1:0]       wr_addr;
	logic [AddrW-1:0]       rd_addr;
	mms_pkg::entry_t        new_entry;
	logic [mms_pkg::DataW:0] diff;

	always_comb begin
		is_push = (req.action == mms_pkg::ACT_PUSH);
		is_pop  = (req.action == mms_pkg::ACT_POP);
		empty   = (count_q == '0);
		full    = (count_q == CntW'(STACK_DEPTH));
		stat.need_read = is_pop && (count_q > CntW'(1));

		new_entry.val = req.value;
		if (empty) begin
			new_entry.hi = req.value;
			new_entry.lo = req.value;
		end else begin
			new_entry.hi = ($signed(req.value) > $signed(top_q.hi)) ? req.value : top_q.hi;
			new_entry.lo = ($signed(req.value) < $signed(top_q.lo)) ? req.value : top_q.lo;
		end

		// The old top moves into memory when a push lands on a non-empty stack.
		mem_we  = cmd.accept && is_push && !full && !empty;
		wr_addr = AddrW'(count_q - CntW'(1));
		rd_addr = AddrW'(count_q - CntW'(2));

		diff = {top_q.hi[mms_pkg::DataW-1], top_q.hi} - {top_q.lo[mms_pkg::DataW-1], top_q.lo};
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= top_q;
		end
		rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			status_q <= mms_pkg::ST_OK;
		end else if (cmd.accept) begin
			status_q <= mms_pkg::ST_OK;
			if (is_push) begin
				if (full) begin
					status_q <= mms_pkg::ST_PUSH_FULL;
				end else begin
					count_q <= count_q + CntW'(1);
				end
			end else if (is_pop) begin
				if (empty) begin
					status_q <= mms_pkg::ST_POP_EMPTY;
				end else begin
					count_q <= count_q - CntW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && is_push && !full) begin
			top_q <= new_entry;
		end else if (cmd.load_top) begin
			top_q <= rdata_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			rsp_q.depth    <= mms_pkg::DepthW'(count_q);
			rsp_q.is_empty <= empty;
			rsp_q.status   <= status_q;
			if (empty) begin
				rsp_q.top_value   <= '0;
				rsp_q.running_max <= '0;
				rsp_q.running_min <= '0;
				rsp_q.spread      <= '0;
			end else begin
				rsp_q.top_value   <= top_q.val;
				rsp_q.running_max <= top_q.hi;
				rsp_q.running_min <= top_q.lo;
				rsp_q.spread      <= diff[mms_pkg::DataW-1:0];
			end
		end
	end

	assign rsp = rsp_q;

endmodule

// ----- hw/rtl/mms_ctrl.sv -----
// ----------------------------------------------------------------------------
// mms_ctrl
// Sequencer: takes a request, waits for the memory read on a pop that
// exposes a stored entry, then loads the response register.
// ----------------------------------------------------------------------------
module mms_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	input  mms_pkg::dp_stat_t   stat,
	output mms_pkg::ctrl_cmd_t  cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOAD,
		S_EMIT
	} state_t;

	state_t state_q;
	logic   rsp_valid_q;

	// A new request is taken in idle once the response register is free or is
	// being emptied in the same cycle.
	always_comb begin
		req_ready    = (state_q == S_IDLE) && (!rsp_valid_q || rsp_ready);
		cmd.accept   = req_valid && req_ready;
		cmd.load_top = (state_q == S_LOAD);
		cmd.emit     = (state_q == S_EMIT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd.accept) begin
						state_q <= stat.need_read ? S_LOAD : S_EMIT;
					end
				end
				S_LOAD: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					rsp_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule
